// File: sv/pvbr_pkg.sv
`timescale 1ns / 1ps
package pvbr_pkg;

  localparam int BIN_W   = 11;
  localparam int AMP_W   = 16;
  localparam int FREQ_W  = 24;
  localparam int SLOT_W  = 12;
  localparam int OUT_W   = 17;
  localparam int PHASE_W = 32;
  localparam int SPC_W   = 24;
  localparam int TPH_W   = 32;
  localparam int PROD_W  = BIN_W + SPC_W;
  localparam int DEV_W   = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BINS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SPACING  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURNS_PER_HZ = 2'd2;

  localparam logic [BIN_W-1:0]   HALF_BINS_RST    = 11'd512;
  localparam logic [SPC_W-1:0]   BIN_SPACING_RST  = 24'd11025;
  localparam logic [TPH_W-1:0]   TURNS_PER_HZ_RST = 32'd12466142;

  // quadrant codes
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam int CORDIC_STEPS = 16;
  localparam logic [15:0] CORDIC_GAIN = 16'd39797;
  localparam int X_W = 35;
  localparam int Z_W = 33;
  localparam logic signed [X_W-1:0] OUT_LIMIT = 35'sd65535;

  function automatic logic [31:0] atan_turn(input int step);
    logic [31:0] a;
    case (step)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // round Q.16 to Q.0 (floor after adding a half) and clamp
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [X_W-1:0] v);
    logic signed [X_W-1:0] t;
    logic signed [X_W-1:0] r;
    logic signed [OUT_W-1:0] o;
    t = v + 35'sd32768;
    r = t >>> 16;
    if (r > OUT_LIMIT) o = 17'sd65535;
    else if (r < -OUT_LIMIT) o = -17'sd65535;
    else o = r[OUT_W-1:0];
    return o;
  endfunction

endpackage

// File: sv/pvbr_ram.sv
`timescale 1ns / 1ps
module pvbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // read during write to the same entry returns the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: sv/phase_vocoder_bin_resynth.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | bin_index, amplitude, frequency, first_frame
// out     | output    | out_valid_o/out_ready_i | real_slot, imag_valid, real_part, imag_part
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled.
// Phase store is one RAM (read at acceptance, written back from stage C); items
// for the same bin in flight pick up the newer phase by forwarding.
// After reset a clearing pass zeroes all MAX_HALF_BINS+1 store entries
// (1025 by default) with in_ready_o low; cfg writes are taken throughout.
// A stalled output holds the whole pipeline; out-of-range bins are taken and dropped.
module phase_vocoder_bin_resynth #(
  parameter int MAX_HALF_BINS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pvbr_pkg::BIN_W-1:0]        bin_index_i,
  input  logic [pvbr_pkg::AMP_W-1:0]        amplitude_i,
  input  logic signed [pvbr_pkg::FREQ_W-1:0] frequency_i,
  input  logic                              first_frame_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pvbr_pkg::SLOT_W-1:0]       real_slot_o,
  output logic                              imag_valid_o,
  output logic signed [pvbr_pkg::OUT_W-1:0] real_part_o,
  output logic signed [pvbr_pkg::OUT_W-1:0] imag_part_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pvbr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pvbr_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import pvbr_pkg::*;

  localparam int DEPTH = MAX_HALF_BINS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int N     = CORDIC_STEPS;

  // configuration
  logic [BIN_W-1:0] half_bins_q;
  logic [SPC_W-1:0] bin_spacing_q;
  logic [TPH_W-1:0] turns_per_hz_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_bins_q    <= HALF_BINS_RST;
      bin_spacing_q  <= BIN_SPACING_RST;
      turns_per_hz_q <= TURNS_PER_HZ_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HALF_BINS:    half_bins_q    <= cfg_data_i[BIN_W-1:0];
        REG_BIN_SPACING:  bin_spacing_q  <= cfg_data_i[SPC_W-1:0];
        REG_TURNS_PER_HZ: turns_per_hz_q <= cfg_data_i[TPH_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass over the phase store
  logic          clr_busy_q;
  logic [CW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == CW'(DEPTH - 1)) clr_busy_q <= 1'b0;
    end
  end

  // whole pipeline moves unless a finished item is held at the output
  logic adv;
  logic acc;
  logic in_rng;
  logic out_vld_q;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv && !clr_busy_q;
  assign acc        = in_valid_i && in_ready_o;
  assign in_rng     = (bin_index_i <= half_bins_q) && (int'(bin_index_i) <= MAX_HALF_BINS);

  // stage A: RAM read in flight, centre frequency product
  logic                     a_vld_q, a_first_q, a_top_q, a_fwd_q;
  logic [AW-1:0]            a_addr_q;
  logic [AMP_W-1:0]         a_amp_q;
  logic signed [FREQ_W-1:0] a_freq_q;
  logic [PROD_W-1:0]        a_prod_q;
  logic [SLOT_W-1:0]        a_slot_q;
  logic [PHASE_W-1:0]       a_fwdd_q;

  // stage B: deviation
  logic                     b_vld_q, b_first_q, b_top_q;
  logic [AW-1:0]            b_addr_q;
  logic [AMP_W-1:0]         b_amp_q;
  logic [DEV_W-1:0]         b_dev_q;
  logic [SLOT_W-1:0]        b_slot_q;
  logic [PHASE_W-1:0]       b_base_q;

  // stage C: partial products, phase update and write back
  logic                     c_vld_q, c_first_q, c_top_q;
  logic [AW-1:0]            c_addr_q;
  logic [AMP_W-1:0]         c_amp_q;
  logic [47:0]              c_lo_q;
  logic [23:0]              c_hi_q;
  logic [SLOT_W-1:0]        c_slot_q;
  logic [PHASE_W-1:0]       c_base_q;

  logic [PHASE_W-1:0] rdata;
  logic [PHASE_W-1:0] base_a;
  logic [PHASE_W-1:0] inc;
  logic [PHASE_W-1:0] new_phase;
  logic               wr_en;
  logic [AW-1:0]      ram_waddr;
  logic [PHASE_W-1:0] ram_wdata;
  logic [DEV_W-1:0]   dev;
  logic [47:0]        lo_prod;
  logic [47:0]        hi_prod;

  assign wr_en     = c_vld_q && adv;
  assign ram_waddr = clr_busy_q ? clr_cnt_q[AW-1:0] : c_addr_q;
  assign ram_wdata = clr_busy_q ? '0 : new_phase;

  pvbr_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (DEPTH)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (clr_busy_q || wr_en),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (acc),
    .raddr_i (AW'(bin_index_i)),
    .rdata_o (rdata)
  );

  // the RAM misses a write landing on the same edge as its read
  assign base_a  = a_fwd_q ? a_fwdd_q : rdata;
  assign dev     = {{(DEV_W-FREQ_W){a_freq_q[FREQ_W-1]}}, a_freq_q}
                 - {{(DEV_W-PROD_W){1'b0}}, a_prod_q};
  // only bits 39:8 of dev*turns matter: split dev at bit 16
  assign lo_prod = {32'd0, b_dev_q[15:0]} * {16'd0, turns_per_hz_q};
  assign hi_prod = {24'd0, b_dev_q[39:16]} * {24'd0, turns_per_hz_q[23:0]};
  assign inc       = c_lo_q[39:8] + {c_hi_q, 8'd0};
  assign new_phase = (c_first_q ? '0 : c_base_q) + inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= acc && in_rng;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_addr_q  <= AW'(bin_index_i);
      a_amp_q   <= amplitude_i;
      a_freq_q  <= frequency_i;
      a_first_q <= first_frame_i;
      a_top_q   <= (bin_index_i == half_bins_q);
      a_slot_q  <= (bin_index_i == half_bins_q) ? SLOT_W'(1) : {bin_index_i, 1'b0};
      a_prod_q  <= {{(PROD_W-BIN_W){1'b0}}, bin_index_i} * {{(PROD_W-SPC_W){1'b0}}, bin_spacing_q};
      a_fwd_q   <= wr_en && (c_addr_q == AW'(bin_index_i));
      a_fwdd_q  <= new_phase;

      b_addr_q  <= a_addr_q;
      b_amp_q   <= a_amp_q;
      b_first_q <= a_first_q;
      b_top_q   <= a_top_q;
      b_slot_q  <= a_slot_q;
      b_dev_q   <= dev;
      b_base_q  <= (wr_en && c_addr_q == a_addr_q) ? new_phase : base_a;

      c_addr_q  <= b_addr_q;
      c_amp_q   <= b_amp_q;
      c_first_q <= b_first_q;
      c_top_q   <= b_top_q;
      c_slot_q  <= b_slot_q;
      c_lo_q    <= lo_prod;
      c_hi_q    <= hi_prod[23:0];
      c_base_q  <= (wr_en && c_addr_q == b_addr_q) ? new_phase : b_base_q;
    end
  end

  // quadrant split of the new phase
  logic [PHASE_W-1:0] ph_off;
  logic [1:0]         quad;
  logic [PHASE_W-1:0] resid;
  logic [31:0]        amp_gain;

  assign ph_off   = new_phase + 32'h2000_0000;
  assign quad     = ph_off[31:30];
  assign resid    = new_phase - {quad, 30'd0};
  assign amp_gain = {16'd0, c_amp_q} * {16'd0, CORDIC_GAIN};

  // CORDIC rotation, one step per stage
  logic                    k_vld_q  [0:N];
  logic                    k_top_q  [0:N];
  logic [1:0]              k_quad_q [0:N];
  logic [SLOT_W-1:0]       k_slot_q [0:N];
  logic signed [X_W-1:0]   k_x_q    [0:N];
  logic signed [X_W-1:0]   k_y_q    [0:N];
  logic signed [Z_W-1:0]   k_z_q    [0:N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_vld_q[0] <= 1'b0;
    end else if (adv) begin
      k_vld_q[0] <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_top_q[0]  <= c_top_q;
      k_quad_q[0] <= quad;
      k_slot_q[0] <= c_slot_q;
      k_x_q[0]    <= {3'd0, amp_gain};
      k_y_q[0]    <= '0;
      k_z_q[0]    <= {resid[31], resid};
    end
  end

  for (genvar gi = 0; gi < N; gi++) begin : g_cordic
    logic signed [X_W-1:0] dx;
    logic signed [X_W-1:0] dy;
    logic signed [Z_W-1:0] ang;

    assign dx  = k_y_q[gi] >>> gi;
    assign dy  = k_x_q[gi] >>> gi;
    assign ang = {1'b0, atan_turn(gi)};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        k_vld_q[gi+1] <= 1'b0;
      end else if (adv) begin
        k_vld_q[gi+1] <= k_vld_q[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        k_top_q[gi+1]  <= k_top_q[gi];
        k_quad_q[gi+1] <= k_quad_q[gi];
        k_slot_q[gi+1] <= k_slot_q[gi];
        if (!k_z_q[gi][Z_W-1]) begin
          k_x_q[gi+1] <= k_x_q[gi] - dx;
          k_y_q[gi+1] <= k_y_q[gi] + dy;
          k_z_q[gi+1] <= k_z_q[gi] - ang;
        end else begin
          k_x_q[gi+1] <= k_x_q[gi] + dx;
          k_y_q[gi+1] <= k_y_q[gi] - dy;
          k_z_q[gi+1] <= k_z_q[gi] + ang;
        end
      end
    end
  end

  // rounding, quadrant turn, output register
  logic signed [OUT_W-1:0] xr, yr, cos_v, sin_v;
  logic [SLOT_W-1:0]       slot_q;
  logic                    imag_vld_q;
  logic signed [OUT_W-1:0] re_q, im_q;

  assign xr = round_sat(k_x_q[N]);
  assign yr = round_sat(k_y_q[N]);

  always_comb begin
    case (k_quad_q[N])
      QUAD_0:  begin cos_v = xr;  sin_v = yr;  end
      QUAD_1:  begin cos_v = -yr; sin_v = xr;  end
      QUAD_2:  begin cos_v = -xr; sin_v = -yr; end
      QUAD_3:  begin cos_v = yr;  sin_v = -xr; end
      default: begin cos_v = xr;  sin_v = yr;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= k_vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      slot_q     <= k_slot_q[N];
      imag_vld_q <= !k_top_q[N];
      re_q       <= cos_v;
      im_q       <= k_top_q[N] ? '0 : -sin_v;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign real_slot_o  = slot_q;
  assign imag_valid_o = imag_vld_q;
  assign real_part_o  = re_q;
  assign imag_part_o  = im_q;

endmodule

// File: sv/phase_vocoder_bin_resynth_checker.sv
`timescale 1ns / 1ps
module pvbr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [pvbr_pkg::SLOT_W-1:0]       real_slot_o,
  input logic                              imag_valid_o,
  input logic signed [pvbr_pkg::OUT_W-1:0] real_part_o,
  input logic signed [pvbr_pkg::OUT_W-1:0] imag_part_o
);
  import pvbr_pkg::*;

  // held item stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(real_part_o)
      && $stable(imag_part_o) && $stable(real_slot_o))
    else $error("output item changed while stalled");

  // top bin: slot 1 and no imaginary part
  a_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !imag_valid_o |-> real_slot_o == SLOT_W'(1) && imag_part_o == '0)
    else $error("top bin item malformed");

  // ordinary bins land on even slots
  a_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && imag_valid_o |-> !real_slot_o[0])
    else $error("odd slot for ordinary bin");

  // saturation keeps both parts off the most negative code
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> real_part_o != -17'sd65536 && imag_part_o != -17'sd65536)
    else $error("output outside saturation range");

endmodule

bind phase_vocoder_bin_resynth pvbr_checker u_pvbr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .real_slot_o  (real_slot_o),
  .imag_valid_o (imag_valid_o),
  .real_part_o  (real_part_o),
  .imag_part_o  (imag_part_o)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import pvbr_pkg::*;

  localparam int MAXB = 1024;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN = 60;

  // Bin resynthesis predictor: running phase per bin plus the three registers.
  typedef struct packed {
    logic [SLOT_W-1:0]        slot;
    logic                     imv;
    logic signed [OUT_W-1:0]  re;
    logic signed [OUT_W-1:0]  im;
  } bin_out_t;

  class bin_scoreboard;
    logic [31:0] phase_mem [0:MAXB];
    logic [10:0] half_bins;
    logic [23:0] spacing;
    logic [31:0] tph;
    bin_out_t    pending [$];
    int          errors;

    function void init();
      for (int i = 0; i <= MAXB; i++) phase_mem[i] = '0;
      half_bins = HALF_BINS_RST;
      spacing = BIN_SPACING_RST;
      tph = TURNS_PER_HZ_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] d);
      if (idx == REG_HALF_BINS) half_bins = d[10:0];
      else if (idx == REG_BIN_SPACING) spacing = d[23:0];
      else if (idx == REG_TURNS_PER_HZ) tph = d;
    endfunction

    // floor division by 2^16 of v + half, then clamp
    function longint rnd(longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > 65535) r = 65535;
      if (r < -65535) r = -65535;
      return r;
    endfunction

    function void note_input(logic [10:0] b, logic [15:0] amp,
                             logic signed [23:0] f, logic first);
      longint dev, x, y, z, dx, dy, xr, yr, c, s;
      logic [63:0] prod;
      logic [31:0] inc, ph, rres;
      logic [1:0] q;
      bin_out_t o;
      if (b > half_bins || b > MAXB) return;  // dropped, no phase update
      dev = longint'(f) - longint'(b) * longint'(spacing);
      prod = 64'(dev) * 64'(tph);
      inc = prod[39:8];
      ph = (first ? 32'd0 : phase_mem[b]) + inc;
      phase_mem[b] = ph;
      q = 2'((ph + 32'h2000_0000) >> 30);
      rres = ph - {q, 30'd0};
      z = longint'($signed(rres));
      x = longint'(amp) * longint'(CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_turn(i));
        end else begin
          x += dx; y -= dy; z += longint'(atan_turn(i));
        end
      end
      xr = rnd(x);
      yr = rnd(y);
      case (q)
        QUAD_0: begin c = xr; s = yr; end
        QUAD_1: begin c = -yr; s = xr; end
        QUAD_2: begin c = -xr; s = -yr; end
        default: begin c = yr; s = -xr; end
      endcase
      if (b == half_bins) begin
        o.slot = 12'd1; o.imv = 1'b0; o.im = '0;
      end else begin
        o.slot = {b, 1'b0}; o.imv = 1'b1; o.im = 17'(-s);
      end
      o.re = 17'(c);
      pending.push_back(o);
    endfunction

    function void check_result(bin_out_t a);
      bin_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result slot=%0d", a.slot);
        return;
      end
      e = pending.pop_front();
      if (a !== e) begin
        errors++;
        if (errors <= 10)
          $display("result differs: exp slot=%0d iv=%0b re=%0d im=%0d got slot=%0d iv=%0b re=%0d im=%0d",
                   e.slot, e.imv, e.re, e.im, a.slot, a.imv, a.re, a.im);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [BIN_W-1:0] bin_index_i = '0;
  logic [AMP_W-1:0] amplitude_i = '0;
  logic signed [FREQ_W-1:0] frequency_i = '0;
  logic first_frame_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SLOT_W-1:0] real_slot_o;
  logic imag_valid_o;
  logic signed [OUT_W-1:0] real_part_o, imag_part_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  bin_scoreboard sb;
  int unsigned cycles = 0;
  bit long_hold = 1'b0;      // receiver holds off while set
  bit hold_req = 1'b0;       // raised by the sender when the hold-off should start
  bit hold_done = 1'b0;

  always #4 clk_i = ~clk_i;

  phase_vocoder_bin_resynth u_top (.*);

  // result monitor: sampled at the edge, before the NBA region moves anything
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{real_slot_o, imag_valid_o, real_part_o, imag_part_o});
  end

  // receiver: own stall pattern, bursts of ready, plus the long hold-off
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) out_ready_i <= 1'b0;
      else begin
        mode = (cycles / 300) % 3;
        if (mode == 0) out_ready_i <= 1'b1;
        else if (mode == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
        else out_ready_i <= ($urandom_range(0, 1) != 0);
      end
    end
  end

  // long receiver hold-off, counted here in cycles
  initial begin
    wait (hold_req);
    long_hold = 1'b1;
    repeat (200) @(posedge clk_i);
    long_hold = 1'b0;
    hold_done = 1'b1;
  end

  initial begin
    wait (cycles == CYCLE_LIMIT);
    $display("phase_vocoder_bin_resynth: mismatch");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    cfg_index_i <= idx;
    cfg_data_i <= d;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  // offer one item, hold it until taken; leaves valid high for back-to-back
  task automatic send_bin(input logic [10:0] b, input logic [15:0] amp,
                          input logic [23:0] f, input logic first);
    bin_index_i <= b;
    amplitude_i <= amp;
    frequency_i <= f;
    first_frame_i <= first;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(b, amp, f, first);
  endtask

  task automatic pause_sender();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // let everything drain, then leave room for a dropped bin still in flight
  task automatic wait_idle();
    pause_sender();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // random bin biased to the configured range, with some out-of-range ones
  task automatic send_random(input int hb, input bit burst_gaps);
    logic [10:0] b;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) b = 11'($urandom);
    else if (r == 1) b = 11'(hb);
    else if (r == 2) b = 11'(hb + 1);
    else b = 11'($urandom_range(0, hb));
    send_bin(b, 16'($urandom), 24'($urandom), ($urandom_range(0, 7) == 0));
    if (burst_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  initial begin
    int hb;
    sb = new();
    sb.init();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, top bin, out-of-range, first frame
    send_bin(11'd0, 16'd0, 24'h000000, 1'b1);
    send_bin(11'd0, 16'hFFFF, 24'h7FFFFF, 1'b0);
    send_bin(11'd0, 16'hFFFF, 24'h800000, 1'b0);
    send_bin(11'd1, 16'hFFFF, 24'hFFFFFF, 1'b1);
    send_bin(11'd512, 16'hFFFF, 24'h123456, 1'b0);   // top bin
    send_bin(11'd513, 16'hAAAA, 24'h555555, 1'b0);   // above top: dropped
    send_bin(11'h7FF, 16'h5555, 24'hAAAAAA, 1'b1);   // beyond store: dropped
    send_bin(11'd100, 16'h8000, 24'h010000, 1'b0);
    send_bin(11'd100, 16'h8000, 24'h010000, 1'b0);   // same bin back to back
    send_bin(11'd100, 16'h7FFF, 24'hFF0000, 1'b0);
    send_bin(11'd511, 16'd1, 24'h000001, 1'b1);
    send_bin(11'h2AA, 16'h1234, 24'h000100, 1'b0);
    wait_idle();

    // configuration sweep, extremes included; each phase runs random bins
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin hb = 1024; write_reg(REG_HALF_BINS, 32'd1024);
          write_reg(REG_BIN_SPACING, 32'hFFFFFF); write_reg(REG_TURNS_PER_HZ, 32'hFFFFFFFF); end
        1: begin hb = 2; write_reg(REG_HALF_BINS, 32'd2);
          write_reg(REG_BIN_SPACING, 32'd0); write_reg(REG_TURNS_PER_HZ, 32'd0); end
        2: begin hb = 0; write_reg(REG_HALF_BINS, 32'd0); end
        3: begin hb = 1; write_reg(REG_HALF_BINS, 32'd1);
          write_reg(REG_TURNS_PER_HZ, 32'h8000_0000); end
        4: begin hb = 7; write_reg(REG_HALF_BINS, 32'd7);
          write_reg(REG_BIN_SPACING, 32'd5_000); write_reg(REG_TURNS_PER_HZ, 32'd99_999_999); end
        5: begin hb = 2047; write_reg(REG_HALF_BINS, 32'h7FF); end
        default: begin hb = 512; write_reg(REG_HALF_BINS, 32'd512);
          write_reg(REG_BIN_SPACING, 32'd11025); write_reg(REG_TURNS_PER_HZ, 32'd12466142); end
      endcase
      // receiver holds off while this phase streams in
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < 100; n++) send_random(hb > 1024 ? 1024 : hb, 1'b1);
      if (ph == 3) begin
        // keep offering until the long hold-off has come and gone
        while (!hold_done) send_random(hb, 1'b0);
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("phase_vocoder_bin_resynth: match");
    else
      $display("phase_vocoder_bin_resynth: mismatch");
    $finish;
  end
endmodule

// File: phase_vocoder_bin_resynth.f
sv/pvbr_pkg.sv
sv/pvbr_ram.sv
sv/phase_vocoder_bin_resynth.sv
sv/phase_vocoder_bin_resynth_checker.sv
tb/tb.sv
